### hdl/lkvc_pkg.sv
// lkvc_pkg: request and response types, op codes and field widths
// for the lru key-value cache. No dependencies.
package lkvc_pkg;

    // field widths fixed by the request and response formats
    localparam int KEY_W   = 32;
    localparam int VALUE_W = 64;
    localparam int CNT_W   = 5;
    localparam int CAP_W   = 5;
    localparam int OP_W    = 3;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // operation codes, codes above OP_CLEAR do nothing
    localparam logic [OP_W-1:0] OP_EXISTS = 3'd0;
    localparam logic [OP_W-1:0] OP_GET    = 3'd1;
    localparam logic [OP_W-1:0] OP_PUT    = 3'd2;
    localparam logic [OP_W-1:0] OP_ERASE  = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] data_in;
    } t_req;

    typedef struct packed {
        logic               hit;
        logic [VALUE_W-1:0] data_out;
        logic [CNT_W-1:0]   count;
    } t_rsp;

endpackage

### hdl/lkvc_store.sv
// lkvc_store: entry storage, recency ranks, entry count and capacity register,
// with the combinational lookup and next-state update for one request. Uses lkvc_pkg.
module lkvc_store #(
    parameter int ENTRIES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lkvc_pkg::CAP_W-1:0]    i_cfg_wdata,
    input  logic                          i_step,
    input  lkvc_pkg::t_req                i_req,
    output lkvc_pkg::t_rsp                o_rsp
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = ((CNT_W > lkvc_pkg::CAP_W) ? CNT_W : lkvc_pkg::CAP_W) + 1;

    // state
    logic [ENTRIES-1:0]                r_valid;
    logic [lkvc_pkg::KEY_W-1:0]        r_key   [ENTRIES];
    logic [lkvc_pkg::VALUE_W-1:0]      r_value [ENTRIES];
    logic [IDX_W-1:0]                  r_rank  [ENTRIES];
    logic [CNT_W-1:0]                  r_count;
    logic [lkvc_pkg::CAP_W-1:0]        r_cap;

    logic [ENTRIES-1:0]                n_valid;
    logic [lkvc_pkg::KEY_W-1:0]        n_key   [ENTRIES];
    logic [lkvc_pkg::VALUE_W-1:0]      n_value [ENTRIES];
    logic [IDX_W-1:0]                  n_rank  [ENTRIES];
    logic [CNT_W-1:0]                  n_count;

    logic [ENTRIES-1:0]                match;
    logic                              hit_any;
    logic [IDX_W-1:0]                  hit_idx;
    logic [IDX_W-1:0]                  hit_rank;
    logic [IDX_W-1:0]                  lru_rank;
    logic [CMP_W-1:0]                  cap_eff;
    logic                              full;
    logic [ENTRIES-1:0]                valid_kept;
    logic [IDX_W-1:0]                  slot;

    // parallel key compare, lowest matching entry wins
    always_comb begin
        match   = '0;
        hit_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            match[i] = r_valid[i] && (r_key[i] == i_req.key);
        end
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_idx = IDX_W'(i);
            end
        end
        hit_any  = |match;
        hit_rank = r_rank[hit_idx];
    end

    // effective capacity, zero acts as one and large values clamp to the entry count
    always_comb begin
        cap_eff = CMP_W'(r_cap);
        if (cap_eff == '0) begin
            cap_eff = CMP_W'(1);
        end else if (cap_eff > CMP_W'(ENTRIES)) begin
            cap_eff = CMP_W'(ENTRIES);
        end
        full = (CMP_W'(r_count) >= cap_eff);
    end

    // victim is the entry holding the oldest rank; free slot is the lowest one left
    always_comb begin
        lru_rank = IDX_W'(r_count - CNT_W'(1));
        for (int i = 0; i < ENTRIES; i++) begin
            valid_kept[i] = r_valid[i] && !(full && (r_rank[i] == lru_rank));
        end
        slot = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!valid_kept[i]) begin
                slot = IDX_W'(i);
            end
        end
    end

    // next state and response for the request in the input register
    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        n_value = r_value;
        n_rank  = r_rank;
        n_count = r_count;
        o_rsp   = '0;

        unique case (i_req.op) inside
            lkvc_pkg::OP_EXISTS: begin
                o_rsp.hit = hit_any;
            end
            lkvc_pkg::OP_GET, lkvc_pkg::OP_PUT: begin
                o_rsp.hit = hit_any;
                if (hit_any) begin
                    // touch: newer entries age by one
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (r_valid[i] && (r_rank[i] < hit_rank)) begin
                            n_rank[i] = r_rank[i] + IDX_W'(1);
                        end
                    end
                    n_rank[hit_idx] = '0;
                    if (i_req.op == lkvc_pkg::OP_GET) begin
                        o_rsp.data_out = r_value[hit_idx];
                    end else begin
                        n_value[hit_idx] = i_req.data_in;
                    end
                end else if (i_req.op == lkvc_pkg::OP_PUT) begin
                    // insert, evicting the oldest entry when full
                    for (int i = 0; i < ENTRIES; i++) begin
                        n_rank[i] = valid_kept[i] ? (r_rank[i] + IDX_W'(1)) : '0;
                    end
                    n_valid       = valid_kept;
                    n_valid[slot] = 1'b1;
                    n_rank[slot]  = '0;
                    n_key[slot]   = i_req.key;
                    n_value[slot] = i_req.data_in;
                    n_count       = full ? r_count : (r_count + CNT_W'(1));
                end
            end
            lkvc_pkg::OP_ERASE: begin
                o_rsp.hit = hit_any;
                if (hit_any) begin
                    // older entries move up by one
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (r_valid[i] && (r_rank[i] > hit_rank)) begin
                            n_rank[i] = r_rank[i] - IDX_W'(1);
                        end
                    end
                    n_valid[hit_idx] = 1'b0;
                    n_rank[hit_idx]  = '0;
                    n_count          = r_count - CNT_W'(1);
                end
            end
            lkvc_pkg::OP_CLEAR: begin
                n_valid = '0;
                for (int i = 0; i < ENTRIES; i++) begin
                    n_rank[i] = '0;
                end
                n_count = '0;
            end
            default: begin
            end
        endcase

        o_rsp.count = lkvc_pkg::CNT_W'(n_count);
    end

    // control state and capacity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            r_cap   <= lkvc_pkg::CAP_RESET;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (i_step) begin
                r_valid <= n_valid;
                r_count <= n_count;
                r_rank  <= n_rank;
            end
        end
    end

    // keys and values
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_key   <= n_key;
            r_value <= n_value;
        end
    end

endmodule

### hdl/lru_key_value_cache_unit.sv
// lru_key_value_cache_unit: top level with input and result registers around
// the entry store. Uses lkvc_pkg and lkvc_store.
//
//  channel    direction  handshake                     payload
//  request    in         i_req_valid / o_req_ready     i_req  (lkvc_pkg::t_req)
//  response   out        o_rsp_valid / i_rsp_ready     o_rsp  (lkvc_pkg::t_rsp)
//  config     in         i_cfg_we (no wait)            i_cfg_wdata (capacity)
//
// One request per cycle sustained while the response is not stalled; a taken request sits
// in the input register while the key compare and rank update run, and its response
// loads into the result register when the request moves on.
// Reset empties the store, zeroes the ranks and count, and sets capacity to 16.
// A stalled response holds the result register; the input register still takes one
// more request behind it, then ready drops until the response leaves.
module lru_key_value_cache_unit #(
    parameter int ENTRIES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    output logic                          o_req_ready,
    input  lkvc_pkg::t_req                i_req,
    output logic                          o_rsp_valid,
    input  logic                          i_rsp_ready,
    output lkvc_pkg::t_rsp                o_rsp,
    input  logic                          i_cfg_we,
    input  logic [lkvc_pkg::CAP_W-1:0]    i_cfg_wdata
);

    logic           r_req_valid;
    lkvc_pkg::t_req r_req;
    logic           r_rsp_valid;
    lkvc_pkg::t_rsp r_rsp;
    lkvc_pkg::t_rsp rsp;
    logic           advance;

    // the input register moves on when the result register is free or being emptied
    assign advance     = r_req_valid && (!r_rsp_valid || i_rsp_ready);
    assign o_req_ready = !r_req_valid || advance;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // entry store
    lkvc_store #(
        .ENTRIES (ENTRIES)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (advance),
        .i_req       (r_req),
        .o_rsp       (rsp)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else if (i_req_valid && o_req_ready) begin
            r_req_valid <= 1'b1;
        end else if (advance) begin
            r_req_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req_valid && o_req_ready) begin
            r_req <= i_req;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (advance) begin
            r_rsp_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_rsp <= rsp;
        end
    end

    // a processed request always lands in the result register
    a_advance_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_rsp_valid)
        else $error("processed request did not produce a response");

    // a request held back by a stalled response stays in the input register
    a_req_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_req_valid && !advance) |=> (r_req_valid && $stable(r_req)))
        else $error("pending request lost while stalled");

    // clear empties the store and never reports a hit
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (r_req.op == lkvc_pkg::OP_CLEAR)) |=>
        ((o_rsp.count == '0) && !o_rsp.hit))
        else $error("clear left entries behind");

    // nonzero data only comes from a get hit
    a_data_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && (o_rsp.data_out != '0)) |-> o_rsp.hit)
        else $error("data returned without a hit");

    // the entry count never exceeds the store size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (int'(o_rsp.count) <= ENTRIES))
        else $error("entry count above store size");

endmodule
